// ===== design/ets_pkg.sv =====
// shared constants and types for the epoch timekeeper
// no dependencies; imported by the channel interfaces and the top level
`default_nettype none

package ets_pkg;

   // tick rate of the low-rate clock; must be a power of two
   localparam int TICKS_PER_SEC = 8;
   localparam int SEC_SHIFT     = $clog2(TICKS_PER_SEC);
   localparam int DEF_TICK_BITS = 40;

   localparam int FUNC_W    = 3;
   localparam int STATUS_W  = 2;
   localparam int EPOCH_W   = 32;
   localparam int DELTA_W   = 16;
   localparam int CSR_IDX_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [31:0] DEF_PERSIST_INTERVAL = 32'(TICKS_PER_SEC * 5 * 60);
   localparam logic [15:0] DEF_MIN_DELTA        = 16'd30;
   localparam logic [31:0] DEF_MIN_EPOCH        = 32'd1704067200;
   localparam logic [31:0] DEF_MAX_EPOCH        = 32'd4102444800;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_TICK    = 3'd0,
      FUNC_SET     = 3'd1,
      FUNC_RESTORE = 3'd2,
      FUNC_PERSIST = 3'd3,
      FUNC_CONVERT = 3'd4
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_UNKNOWN = 2'd0,
      STAT_STALE   = 2'd1,
      STAT_FRESH   = 2'd2
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PERSIST_INTERVAL = 4'd0,
      CSR_MIN_DELTA        = 4'd1,
      CSR_MIN_EPOCH        = 4'd2,
      CSR_MAX_EPOCH        = 4'd3
   } csr_idx_type;

endpackage

`default_nettype wire

// ===== design/ets_if.sv =====
// valid/ready channel interfaces for the epoch timekeeper: request, response, csr write
// depends on ets_pkg
`default_nettype none

interface ets_req_if import ets_pkg::*; #(
   parameter int TICK_BITS = DEF_TICK_BITS
) ();
   logic                 valid;
   logic                 ready;
   logic [FUNC_W-1:0]    func;
   logic [EPOCH_W-1:0]   epoch_value;
   logic [TICK_BITS-1:0] query_ticks;

   modport source (output valid, func, epoch_value, query_ticks, input ready);
   modport sink   (input valid, func, epoch_value, query_ticks, output ready);
endinterface

interface ets_rsp_if import ets_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [EPOCH_W-1:0]  current_epoch;
   logic [STATUS_W-1:0] sync_status;
   logic [EPOCH_W-1:0]  seconds_since_sync;
   logic [EPOCH_W-1:0]  uptime_seconds;
   logic [EPOCH_W-1:0]  converted_epoch;
   logic                persist_request;
   logic [EPOCH_W-1:0]  persist_epoch;
   logic                accepted;

   modport source (output valid, current_epoch, sync_status, seconds_since_sync,
                   uptime_seconds, converted_epoch, persist_request, persist_epoch,
                   accepted, input ready);
   modport sink   (input valid, current_epoch, sync_status, seconds_since_sync,
                   uptime_seconds, converted_epoch, persist_request, persist_epoch,
                   accepted, output ready);
endinterface

interface ets_csr_if import ets_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] wdata;

   modport source (output valid, index, wdata, input ready);
   modport sink   (input valid, index, wdata, output ready);
endinterface

`default_nettype wire

// ===== design/epoch_timekeeper_with_persist.sv =====
// epoch timekeeper top level: tick counter, epoch base, persist decisions, result register
// depends on ets_pkg and the channel interfaces in ets_if
`default_nettype none

// Keeps wall-clock epoch seconds from a tick count at TICKS_PER_SEC ticks per second.
// Each request (tick, set time, restore saved, persist now, convert ticks) is taken and
// its response appears in the result register on the next cycle; a new request
// is taken every cycle as long as the result register is empty or being drained, so the
// sustained rate is one request per clock and is set by the response channel alone.
// The block never writes storage itself: it raises persist_request with the epoch to store.
// Csr writes are always ready and take effect on the next cycle.
module epoch_timekeeper_with_persist import ets_pkg::*; #(
   parameter int TICK_BITS = DEF_TICK_BITS
) (
   input  wire      clock,
   input  wire      reset,
   ets_req_if.sink  req_in,
   ets_rsp_if.source rsp_out,
   ets_csr_if.sink  csr_in
);

   localparam logic [EPOCH_W-1:0] EPOCH_ALL = '1;

   function automatic logic [EPOCH_W-1:0] sat_secs(input logic [TICK_BITS-1:0] t);
      logic [63:0] s;
      s = 64'(t) >> SEC_SHIFT;
      return (|s[63:32]) ? EPOCH_ALL : s[31:0];
   endfunction

   function automatic logic [EPOCH_W-1:0] sat_add(input logic [EPOCH_W-1:0] a,
                                                  input logic [EPOCH_W-1:0] b);
      logic [EPOCH_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[EPOCH_W] ? EPOCH_ALL : s[EPOCH_W-1:0];
   endfunction

   function automatic logic [EPOCH_W-1:0] epoch_at(input logic [TICK_BITS-1:0] t,
                                                   input logic [TICK_BITS-1:0] bt,
                                                   input logic [EPOCH_W-1:0]   be,
                                                   input status_type           st);
      logic [EPOCH_W-1:0] back;
      back = sat_secs(bt - t);
      if (st == STAT_UNKNOWN || be == '0) return '0;
      if (t >= bt) return sat_add(be, sat_secs(t - bt));
      return (be > back) ? be - back : '0;
   endfunction

   // csr registers
   logic [31:0]        cfg_interval_ff;
   logic [DELTA_W-1:0] cfg_delta_ff;
   logic [EPOCH_W-1:0] cfg_min_ff;
   logic [EPOCH_W-1:0] cfg_max_ff;

   // timekeeping state
   logic [TICK_BITS-1:0] tick_count_ff, tick_count_in;
   logic [TICK_BITS-1:0] base_tick_ff, base_tick_in;
   logic [EPOCH_W-1:0]   base_epoch_ff, base_epoch_in;
   logic [TICK_BITS-1:0] sync_tick_ff, sync_tick_in;
   logic                 ever_synced_ff, ever_synced_in;
   logic [EPOCH_W-1:0]   last_saved_ff, last_saved_in;
   logic [TICK_BITS-1:0] last_save_tick_ff, last_save_tick_in;
   status_type           status_ff, status_in;

   // result register
   logic                rsp_valid_ff;
   logic [EPOCH_W-1:0]  rsp_epoch_ff, rsp_epoch_in;
   status_type          rsp_status_ff;
   logic [EPOCH_W-1:0]  rsp_since_ff, rsp_since_in;
   logic [EPOCH_W-1:0]  rsp_uptime_ff, rsp_uptime_in;
   logic [EPOCH_W-1:0]  rsp_conv_ff, rsp_conv_in;
   logic                rsp_preq_ff, rsp_preq_in;
   logic [EPOCH_W-1:0]  rsp_pepoch_ff, rsp_pepoch_in;
   logic                rsp_acc_ff, rsp_acc_in;

   func_type             req_func;
   logic                 req_fire;
   logic [EPOCH_W-1:0]   now_epoch;
   logic [TICK_BITS-1:0] save_gap;
   logic                 ev_ok;
   logic                 now_ok;
   logic [EPOCH_W-1:0]   save_diff;

   assign req_func     = func_type'(req_in.func);
   assign req_in.ready = !rsp_valid_ff || rsp_out.ready;
   assign req_fire     = req_in.valid && req_in.ready;
   assign csr_in.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_interval_ff <= DEF_PERSIST_INTERVAL;
         cfg_delta_ff    <= DEF_MIN_DELTA;
         cfg_min_ff      <= DEF_MIN_EPOCH;
         cfg_max_ff      <= DEF_MAX_EPOCH;
      end else if (csr_in.valid) begin
         case (csr_idx_type'(csr_in.index))
            CSR_PERSIST_INTERVAL: cfg_interval_ff <= csr_in.wdata;
            CSR_MIN_DELTA:        cfg_delta_ff    <= csr_in.wdata[DELTA_W-1:0];
            CSR_MIN_EPOCH:        cfg_min_ff      <= csr_in.wdata;
            CSR_MAX_EPOCH:        cfg_max_ff      <= csr_in.wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      tick_count_in     = tick_count_ff;
      if (req_fire && req_func == FUNC_TICK) begin
         tick_count_in = tick_count_ff + TICK_BITS'(1);
      end
      base_tick_in      = base_tick_ff;
      base_epoch_in     = base_epoch_ff;
      sync_tick_in      = sync_tick_ff;
      ever_synced_in    = ever_synced_ff;
      last_saved_in     = last_saved_ff;
      last_save_tick_in = last_save_tick_ff;
      status_in         = status_ff;
      rsp_conv_in       = '0;
      rsp_preq_in       = 1'b0;
      rsp_pepoch_in     = '0;
      rsp_acc_in        = 1'b0;

      // epoch at the post-tick count on the current base, for auto and forced persist
      now_epoch = epoch_at(tick_count_in, base_tick_ff, base_epoch_ff, status_ff);
      save_gap  = tick_count_in - last_save_tick_ff;
      ev_ok     = req_in.epoch_value >= cfg_min_ff && req_in.epoch_value <= cfg_max_ff;
      now_ok    = now_epoch >= cfg_min_ff && now_epoch <= cfg_max_ff;
      save_diff = (now_epoch >= last_saved_ff) ? now_epoch - last_saved_ff
                                               : last_saved_ff - now_epoch;

      if (req_fire) begin
         case (req_func)
            FUNC_TICK: begin
               if (save_gap >= TICK_BITS'(cfg_interval_ff)) begin
                  last_save_tick_in = tick_count_in;
                  if (now_epoch != '0 && now_ok &&
                      (last_saved_ff == '0 || save_diff >= EPOCH_W'(cfg_delta_ff))) begin
                     rsp_preq_in   = 1'b1;
                     rsp_pepoch_in = now_epoch;
                     last_saved_in = now_epoch;
                  end
               end
            end
            FUNC_SET: begin
               if (ev_ok) begin
                  rsp_acc_in        = 1'b1;
                  base_tick_in      = tick_count_ff;
                  base_epoch_in     = req_in.epoch_value;
                  sync_tick_in      = tick_count_ff;
                  ever_synced_in    = 1'b1;
                  status_in         = STAT_FRESH;
                  rsp_preq_in       = 1'b1;
                  rsp_pepoch_in     = req_in.epoch_value;
                  last_saved_in     = req_in.epoch_value;
                  last_save_tick_in = tick_count_ff;
               end
            end
            FUNC_RESTORE: begin
               if (ev_ok) begin
                  rsp_acc_in    = 1'b1;
                  base_epoch_in = req_in.epoch_value;
                  base_tick_in  = '0;
                  last_saved_in = req_in.epoch_value;
                  status_in     = STAT_STALE;
               end
            end
            FUNC_PERSIST: begin
               if (now_epoch != '0) begin
                  if (now_ok) begin
                     rsp_preq_in   = 1'b1;
                     rsp_pepoch_in = now_epoch;
                     last_saved_in = now_epoch;
                  end
                  last_save_tick_in = tick_count_ff;
               end
            end
            FUNC_CONVERT: begin
               rsp_conv_in = epoch_at(req_in.query_ticks, base_tick_ff, base_epoch_ff,
                                      status_ff);
            end
            default: ;
         endcase
      end

      // report on the state as it stands after this request
      rsp_epoch_in  = epoch_at(tick_count_in, base_tick_in, base_epoch_in, status_in);
      rsp_uptime_in = sat_secs(tick_count_in);
      if (!ever_synced_in) begin
         rsp_since_in = EPOCH_ALL;
      end else if (tick_count_in >= sync_tick_in) begin
         rsp_since_in = sat_secs(tick_count_in - sync_tick_in);
      end else begin
         rsp_since_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_count_ff     <= '0;
         base_tick_ff      <= '0;
         base_epoch_ff     <= '0;
         sync_tick_ff      <= '0;
         ever_synced_ff    <= 1'b0;
         last_saved_ff     <= '0;
         last_save_tick_ff <= '0;
         status_ff         <= STAT_UNKNOWN;
      end else begin
         tick_count_ff     <= tick_count_in;
         base_tick_ff      <= base_tick_in;
         base_epoch_ff     <= base_epoch_in;
         sync_tick_ff      <= sync_tick_in;
         ever_synced_ff    <= ever_synced_in;
         last_saved_ff     <= last_saved_in;
         last_save_tick_ff <= last_save_tick_in;
         status_ff         <= status_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_out.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_epoch_ff  <= rsp_epoch_in;
         rsp_status_ff <= status_in;
         rsp_since_ff  <= rsp_since_in;
         rsp_uptime_ff <= rsp_uptime_in;
         rsp_conv_ff   <= rsp_conv_in;
         rsp_preq_ff   <= rsp_preq_in;
         rsp_pepoch_ff <= rsp_pepoch_in;
         rsp_acc_ff    <= rsp_acc_in;
      end
   end

   assign rsp_out.valid              = rsp_valid_ff;
   assign rsp_out.current_epoch      = rsp_epoch_ff;
   assign rsp_out.sync_status        = rsp_status_ff;
   assign rsp_out.seconds_since_sync = rsp_since_ff;
   assign rsp_out.uptime_seconds     = rsp_uptime_ff;
   assign rsp_out.converted_epoch    = rsp_conv_ff;
   assign rsp_out.persist_request    = rsp_preq_ff;
   assign rsp_out.persist_epoch      = rsp_pepoch_ff;
   assign rsp_out.accepted           = rsp_acc_ff;

`ifndef SYNTHESIS
   a_fresh_means_synced: assert property (@(posedge clock) disable iff (reset)
      status_ff == STAT_FRESH |-> ever_synced_ff)
      else $error("fresh status without a sync");

   a_tick_advances: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_func == FUNC_TICK |=>
         tick_count_ff == $past(tick_count_ff) + TICK_BITS'(1))
      else $error("tick request did not advance the tick count");

   a_count_holds: assert property (@(posedge clock) disable iff (reset)
      !(req_fire && req_func == FUNC_TICK) |=> $stable(tick_count_ff))
      else $error("tick count moved without a tick request");

   a_unknown_reads_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff == STAT_UNKNOWN |->
         rsp_epoch_ff == '0 && rsp_conv_ff == '0)
      else $error("nonzero epoch reported while time is unknown");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/epoch_timekeeper_with_persist_tb.sv =====
`timescale 1ns / 100ps
// self-checking bench for epoch_timekeeper_with_persist: a directed request table, then
// random requests under several csr settings, checked by typed rows or an in-bench model
// depends on ets_pkg, the channel interfaces in ets_if and the design top level

module epoch_timekeeper_with_persist_tb;
   import ets_pkg::*;

   localparam int TICK_BITS      = DEF_TICK_BITS;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int HOLD_CYCLES    = 80;
   localparam int SETTLE_CYCLES  = 3;
   localparam int MAX_REPORTS    = 10;
   localparam int IDLE_PCT       = 15;
   localparam int ITEMS_PER_PHASE = 235;
   localparam int NUM_PHASES     = 8;
   localparam int NUM_DIRECTED   = 20;
   localparam logic [EPOCH_W-1:0]   ALL_ONES  = '1;
   localparam logic [TICK_BITS-1:0] TICK_ONES = '1;

   // func codes with no operation behind them
   localparam logic [FUNC_W-1:0] FUNC_SPARE_0 = 3'd5;
   localparam logic [FUNC_W-1:0] FUNC_SPARE_1 = 3'd6;
   localparam logic [FUNC_W-1:0] FUNC_SPARE_2 = 3'd7;

   typedef struct packed {
      logic [EPOCH_W-1:0] current_epoch;
      status_type         sync_status;
      logic [EPOCH_W-1:0] seconds_since_sync;
      logic [EPOCH_W-1:0] uptime_seconds;
      logic [EPOCH_W-1:0] converted_epoch;
      logic               persist_request;
      logic [EPOCH_W-1:0] persist_epoch;
      logic               accepted;
   } ets_reading_type;

   typedef struct packed {
      logic [FUNC_W-1:0]    func;
      logic [EPOCH_W-1:0]   epoch_value;
      logic [TICK_BITS-1:0] query_ticks;
      logic                 typed;
      ets_reading_type      want;
   } dir_row_type;

   typedef struct packed {
      logic [31:0] interval;
      logic [15:0] delta;
      logic [31:0] lo;
      logic [31:0] hi;
   } csr_set_type;

   // reading of a block that has never been set or restored, one tick after reset
   localparam ets_reading_type BOOT_READING =
      '{32'd0, STAT_UNKNOWN, ALL_ONES, 32'd0, 32'd0, 1'b0, 32'd0, 1'b0};

   dir_row_type directed_rows [NUM_DIRECTED] = '{
      '{FUNC_TICK,     32'd0,             40'd0,     1'b1, BOOT_READING},
      '{FUNC_CONVERT,  32'd0,             TICK_ONES, 1'b1, BOOT_READING},
      '{FUNC_PERSIST,  32'd0,             40'd0,     1'b1, BOOT_READING},
      '{FUNC_SET,      DEF_MIN_EPOCH - 1, 40'd0,     1'b1, BOOT_READING},
      '{FUNC_SET,      DEF_MAX_EPOCH + 1, 40'd0,     1'b1, BOOT_READING},
      '{FUNC_RESTORE,  32'd0,             40'd0,     1'b1, BOOT_READING},
      '{FUNC_RESTORE,  DEF_MIN_EPOCH,     40'd0,     1'b1,
        '{DEF_MIN_EPOCH, STAT_STALE, ALL_ONES, 32'd0, 32'd0, 1'b0, 32'd0, 1'b1}},
      '{FUNC_CONVERT,  32'd0,             40'd0,     1'b0, '0},
      '{FUNC_TICK,     32'd0,             40'd0,     1'b0, '0},
      '{FUNC_PERSIST,  32'd0,             40'd0,     1'b0, '0},
      '{FUNC_SET,      DEF_MAX_EPOCH,     40'd0,     1'b1,
        '{DEF_MAX_EPOCH, STAT_FRESH, 32'd0, 32'd0, 32'd0, 1'b1, DEF_MAX_EPOCH, 1'b1}},
      '{FUNC_CONVERT,  32'd0,             40'd0,     1'b0, '0},
      '{FUNC_CONVERT,  32'd0,             TICK_ONES, 1'b0, '0},
      '{FUNC_SET,      ALL_ONES,          40'd0,     1'b0, '0},
      '{FUNC_SPARE_0,  ALL_ONES,          TICK_ONES, 1'b0, '0},
      '{FUNC_SPARE_1,  ALL_ONES,          TICK_ONES, 1'b0, '0},
      '{FUNC_SPARE_2,  ALL_ONES,          TICK_ONES, 1'b0, '0},
      '{FUNC_RESTORE,  DEF_MAX_EPOCH,     40'd0,     1'b0, '0},
      '{FUNC_TICK,     ALL_ONES,          TICK_ONES, 1'b0, '0},
      '{FUNC_CONVERT,  32'd0,             40'h10,    1'b0, '0}
   };

   // one csr setting per random phase: defaults, interval of zero, empty range, extremes
   csr_set_type csr_plan [NUM_PHASES] = '{
      '{DEF_PERSIST_INTERVAL, DEF_MIN_DELTA, DEF_MIN_EPOCH,  DEF_MAX_EPOCH},
      '{32'd4,                16'd2,         32'd1000,       32'd5000},
      '{32'd0,                16'd0,         32'd0,          ALL_ONES},
      '{32'd1,                16'hFFFF,      32'd100,        32'd200},
      '{ALL_ONES,             16'd30,        32'hFFFF_FFF0,  ALL_ONES},
      '{32'd3,                16'd1,         32'd5000,       32'd1000},
      '{32'd17,               16'd5,         DEF_MIN_EPOCH,  DEF_MAX_EPOCH},
      '{32'd2,                16'd1,         32'd0,          32'd10}
   };

   logic clock = 1'b0;
   logic reset;

   ets_req_if #(.TICK_BITS(TICK_BITS)) req_bus ();
   ets_rsp_if rsp_bus ();
   ets_csr_if csr_bus ();

   epoch_timekeeper_with_persist #(.TICK_BITS(TICK_BITS)) u_top (
      .clock   (clock),
      .reset   (reset),
      .req_in  (req_bus),
      .rsp_out (rsp_bus),
      .csr_in  (csr_bus)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   // timekeeper model state and its copy of the csr settings
   logic [TICK_BITS-1:0] tick_cnt, base_tk, sync_tk, save_tk;
   logic [EPOCH_W-1:0]   base_ep, saved_ep;
   logic                 synced;
   status_type           status;
   logic [31:0]          cfg_interval;
   logic [15:0]          cfg_delta;
   logic [31:0]          cfg_min, cfg_max;

   ets_reading_type readings_due [$];
   ets_reading_type due;
   int  fail_count  = 0;
   int  idle_cycles = 0;
   bit  calm        = 1'b0;
   bit  want_hold   = 1'b0;
   bit  hold_done   = 1'b0;

   function automatic logic [31:0] secs_sat(input logic [TICK_BITS-1:0] ticks);
      logic [TICK_BITS-1:0] s;
      s = ticks / TICKS_PER_SEC;
      return (s > TICK_BITS'(ALL_ONES)) ? ALL_ONES : s[31:0];
   endfunction

   function automatic bit in_window(input logic [EPOCH_W-1:0] e);
      return e >= cfg_min && e <= cfg_max;
   endfunction

   function automatic logic [EPOCH_W-1:0] epoch_at_tick(input logic [TICK_BITS-1:0] t);
      logic [EPOCH_W:0]   sum;
      logic [EPOCH_W-1:0] back;
      if (status == STAT_UNKNOWN || base_ep == '0) return '0;
      if (t >= base_tk) begin
         sum = {1'b0, base_ep} + {1'b0, secs_sat(t - base_tk)};
         return sum[EPOCH_W] ? ALL_ONES : sum[EPOCH_W-1:0];
      end
      back = secs_sat(base_tk - t);
      return (base_ep > back) ? base_ep - back : '0;
   endfunction

   // records the epoch as saved when a write is due
   function automatic bit claim_persist(input logic [EPOCH_W-1:0] e, input bit forced);
      logic [EPOCH_W-1:0] gap;
      if (!in_window(e)) return 1'b0;
      if (!forced && saved_ep != '0) begin
         gap = (e >= saved_ep) ? e - saved_ep : saved_ep - e;
         if (gap < {16'd0, cfg_delta}) return 1'b0;
      end
      saved_ep = e;
      return 1'b1;
   endfunction

   function automatic ets_reading_type step_timekeeper(input logic [FUNC_W-1:0] fn,
                                                       input logic [EPOCH_W-1:0] ev,
                                                       input logic [TICK_BITS-1:0] q);
      ets_reading_type r;
      logic [EPOCH_W-1:0] now;
      r = '0;
      case (fn)
         FUNC_TICK: begin
            tick_cnt = tick_cnt + 1'b1;
            if (tick_cnt - save_tk >= cfg_interval) begin
               now = epoch_at_tick(tick_cnt);
               save_tk = tick_cnt;
               if (now != '0 && claim_persist(now, 1'b0)) begin
                  r.persist_request = 1'b1;
                  r.persist_epoch = now;
               end
            end
         end
         FUNC_SET: begin
            if (in_window(ev)) begin
               r.accepted = 1'b1;
               base_tk = tick_cnt;
               base_ep = ev;
               sync_tk = tick_cnt;
               synced = 1'b1;
               status = STAT_FRESH;
               if (claim_persist(ev, 1'b1)) begin
                  r.persist_request = 1'b1;
                  r.persist_epoch = ev;
               end
               save_tk = tick_cnt;
            end
         end
         FUNC_RESTORE: begin
            if (in_window(ev)) begin
               r.accepted = 1'b1;
               base_ep = ev;
               base_tk = '0;
               saved_ep = ev;
               status = STAT_STALE;
            end
         end
         FUNC_PERSIST: begin
            now = epoch_at_tick(tick_cnt);
            if (now != '0) begin
               if (claim_persist(now, 1'b1)) begin
                  r.persist_request = 1'b1;
                  r.persist_epoch = now;
               end
               save_tk = tick_cnt;
            end
         end
         FUNC_CONVERT: r.converted_epoch = epoch_at_tick(q);
         default: ;
      endcase
      r.current_epoch = epoch_at_tick(tick_cnt);
      r.sync_status = status;
      if (!synced)
         r.seconds_since_sync = ALL_ONES;
      else
         r.seconds_since_sync = (tick_cnt >= sync_tk) ? secs_sat(tick_cnt - sync_tk) : '0;
      r.uptime_seconds = secs_sat(tick_cnt);
      return r;
   endfunction

   task automatic reset_model();
      tick_cnt = '0;
      base_tk = '0;
      sync_tk = '0;
      save_tk = '0;
      base_ep = '0;
      saved_ep = '0;
      synced = 1'b0;
      status = STAT_UNKNOWN;
      cfg_interval = DEF_PERSIST_INTERVAL;
      cfg_delta = DEF_MIN_DELTA;
      cfg_min = DEF_MIN_EPOCH;
      cfg_max = DEF_MAX_EPOCH;
   endtask

   function automatic logic [EPOCH_W-1:0] pick_epoch();
      logic [EPOCH_W:0] span;
      logic [63:0]      r;
      case ($urandom_range(9))
         0: return cfg_min;
         1: return cfg_max;
         2: return cfg_min - 1'b1;
         3: return cfg_max + 1'b1;
         4: return $urandom;
         5: return '0;
         default: begin
            if (cfg_min > cfg_max) return $urandom;
            span = {1'b0, cfg_max} - {1'b0, cfg_min} + 1'b1;
            r = {$urandom, $urandom};
            return cfg_min + 32'(r % span);
         end
      endcase
   endfunction

   function automatic logic [TICK_BITS-1:0] pick_query();
      logic [63:0] r;
      r = {$urandom, $urandom};
      case ($urandom_range(5))
         0: return '0;
         1: return TICK_ONES;
         2: return tick_cnt;
         3: return tick_cnt + TICK_BITS'($urandom_range(400)) - TICK_BITS'(200);
         4: return base_tk - TICK_BITS'($urandom_range(400));
         default: return r[TICK_BITS-1:0];
      endcase
   endfunction

   // mostly ticks so the auto persist check gets exercised
   function automatic logic [FUNC_W-1:0] pick_func();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 55) return FUNC_TICK;
      if (roll < 65) return FUNC_SET;
      if (roll < 73) return FUNC_RESTORE;
      if (roll < 81) return FUNC_PERSIST;
      if (roll < 95) return FUNC_CONVERT;
      case ($urandom_range(2))
         0: return FUNC_SPARE_0;
         1: return FUNC_SPARE_1;
         default: return FUNC_SPARE_2;
      endcase
   endfunction

   task automatic flag_failure(input string msg);
      fail_count++;
      if (fail_count <= MAX_REPORTS) $display("%0t ns: %s", $time, msg);
   endtask

   task automatic compare_field(input string name, input logic [31:0] got,
                                input logic [31:0] want);
      if (got !== want) flag_failure($sformatf("%s expected %h got %h", name, want, got));
   endtask

   task automatic send_request(input logic [FUNC_W-1:0] fn, input logic [EPOCH_W-1:0] ev,
                               input logic [TICK_BITS-1:0] q, input bit typed,
                               input ets_reading_type want);
      ets_reading_type predicted;
      @(negedge clock);
      if (!calm && $urandom_range(99) < IDLE_PCT) begin
         req_bus.valid = 1'b0;
         @(negedge clock);
      end
      req_bus.valid = 1'b1;
      req_bus.func = fn;
      req_bus.epoch_value = ev;
      req_bus.query_ticks = q;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      // model always advances, even where the row carries its own reading
      predicted = step_timekeeper(fn, ev, q);
      readings_due.push_back(typed ? want : predicted);
   endtask

   task automatic write_csr(input csr_idx_type idx, input logic [31:0] val);
      @(negedge clock);
      csr_bus.valid = 1'b1;
      csr_bus.index = idx;
      csr_bus.wdata = val;
      do @(posedge clock); while (csr_bus.ready !== 1'b1);
      case (idx)
         CSR_PERSIST_INTERVAL: cfg_interval = val;
         CSR_MIN_DELTA:        cfg_delta = val[15:0];
         CSR_MIN_EPOCH:        cfg_min = val;
         CSR_MAX_EPOCH:        cfg_max = val;
         default: ;
      endcase
   endtask

   // sender stops and waits for every response before going on
   task automatic drain_and_settle();
      @(negedge clock);
      req_bus.valid = 1'b0;
      while (readings_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // response side: random back-pressure, one long hold-off on request
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (want_hold && !hold_done) begin
            hold_done = 1'b1;
            rsp_bus.ready = 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
         end else begin
            rsp_bus.ready = calm || ($urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (readings_due.size() == 0) begin
            flag_failure("response with no request outstanding");
         end else begin
            due = readings_due.pop_front();
            compare_field("current_epoch", rsp_bus.current_epoch, due.current_epoch);
            compare_field("sync_status", 32'(rsp_bus.sync_status), 32'(due.sync_status));
            compare_field("seconds_since_sync", rsp_bus.seconds_since_sync,
                          due.seconds_since_sync);
            compare_field("uptime_seconds", rsp_bus.uptime_seconds, due.uptime_seconds);
            compare_field("converted_epoch", rsp_bus.converted_epoch, due.converted_epoch);
            compare_field("persist_request", 32'(rsp_bus.persist_request),
                          32'(due.persist_request));
            compare_field("persist_epoch", rsp_bus.persist_epoch, due.persist_epoch);
            compare_field("accepted", 32'(rsp_bus.accepted), 32'(due.accepted));
         end
      end
   end

   always @(posedge clock) begin
      if ((req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
          (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) ||
          (csr_bus.valid === 1'b1 && csr_bus.ready === 1'b1))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL epoch_timekeeper_with_persist");
         $finish;
      end
   end

   initial begin
      logic [FUNC_W-1:0] fn;
      req_bus.valid = 1'b0;
      req_bus.func = FUNC_TICK;
      req_bus.epoch_value = '0;
      req_bus.query_ticks = '0;
      csr_bus.valid = 1'b0;
      csr_bus.index = CSR_PERSIST_INTERVAL;
      csr_bus.wdata = '0;
      reset = 1'b1;
      reset_model();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed_rows[i])
         send_request(directed_rows[i].func, directed_rows[i].epoch_value,
                      directed_rows[i].query_ticks, directed_rows[i].typed,
                      directed_rows[i].want);

      for (int p = 0; p < NUM_PHASES; p++) begin
         drain_and_settle();
         write_csr(CSR_PERSIST_INTERVAL, csr_plan[p].interval);
         write_csr(CSR_MIN_DELTA, {16'd0, csr_plan[p].delta});
         write_csr(CSR_MIN_EPOCH, csr_plan[p].lo);
         write_csr(CSR_MAX_EPOCH, csr_plan[p].hi);
         @(negedge clock);
         csr_bus.valid = 1'b0;
         // one phase runs with no idling on either side
         calm = (p == 2);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if (p == 3 && n == 60) want_hold = 1'b1;
            fn = pick_func();
            send_request(fn, pick_epoch(), pick_query(), 1'b0, '0);
         end
      end

      drain_and_settle();
      if (fail_count == 0)
         $display("PASS epoch_timekeeper_with_persist");
      else
         $display("FAIL epoch_timekeeper_with_persist");
      $finish;
   end

endmodule
